// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file lsrg_checker.sv
// no dependencies; the including file supplies clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define LSRG_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked during reset
`define LSRG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/lsrg_pkg.sv -----
// shared types and constants of the led strip rainbow generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsrg_pkg;

   localparam int LED_COUNT_DEF = 16;

   localparam logic [15:0] HUE_PERIOD_RST   = 16'd5000;
   localparam logic [15:0] FADE_IN_RST      = 16'd4000;
   localparam logic        BREATH_EN_RST    = 1'b0;
   localparam logic [15:0] BREATH_PERIOD_RST = 16'd2000;

   localparam logic [1:0] REG_HUE_PERIOD    = 2'd0;
   localparam logic [1:0] REG_FADE_IN       = 2'd1;
   localparam logic [1:0] REG_BREATH_EN     = 2'd2;
   localparam logic [1:0] REG_BREATH_PERIOD = 2'd3;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam int SIN_K1    = 102944;
   localparam int SIN_K2    = 42177;
   localparam int SIN_K3    = 4770;
   localparam int BR_BASE   = 6554;
   localparam int BR_GAIN   = 58982;

   typedef struct packed {
      logic [15:0] hue_period;
      logic [15:0] fade_in;
      logic        breath_en;
      logic [15:0] breath_period;
   } cfg_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [16:0] fade;
      logic [16:0] breath;
   } entry_type;

endpackage

`default_nettype wire

// ----- sv/lsrg_div.sv -----
// shared restoring divider, one quotient bit per cycle
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module lsrg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] rem_init,
   input  logic [15:0] dvd,
   input  logic [15:0] den,
   output logic        done,
   output logic [15:0] quot,
   output logic [15:0] rem
);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [15:0] quo_ff;
   logic [15:0] den_ff;
   logic [16:0] shifted;
   logic        ge;
   logic [15:0] rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[15]};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = ge ? 16'(shifted - {1'b0, den_ff}) : shifted[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         quo_ff <= dvd;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[14:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ----- sv/lsrg_front.sv -----
// per-tick front end: timing state, hue phase, fade and breathing factors
// depends on lsrg_pkg and lsrg_div
`timescale 1ns / 1ps
`default_nettype none

module lsrg_front (
   input  logic                clock,
   input  logic                reset,
   input  lsrg_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_now_ms,
   output logic                push,
   output lsrg_pkg::entry_type push_data,
   input  logic                q_full
);

   import lsrg_pkg::*;

   localparam logic [3:0] F_IDLE  = 4'd0;
   localparam logic [3:0] F_HUE   = 4'd1;
   localparam logic [3:0] F_HWAIT = 4'd2;
   localparam logic [3:0] F_RAMP  = 4'd3;
   localparam logic [3:0] F_RWAIT = 4'd4;
   localparam logic [3:0] F_SQRT  = 4'd5;
   localparam logic [3:0] F_BMOD  = 4'd6;
   localparam logic [3:0] F_MWAIT = 4'd7;
   localparam logic [3:0] F_PWAIT = 4'd8;
   localparam logic [3:0] F_SIN1  = 4'd9;
   localparam logic [3:0] F_SIN2  = 4'd10;
   localparam logic [3:0] F_SIN3  = 4'd11;
   localparam logic [3:0] F_SIN4  = 4'd12;
   localparam logic [3:0] F_SIN5  = 4'd13;
   localparam logic [3:0] F_PUSH  = 4'd14;

   localparam logic [4:0] SQRT_LAST = 5'd16;

   function automatic logic [16:0] sine_arg(input logic [15:0] p);
      logic [14:0] t;
      t = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
      return {t, 2'b00};
   endfunction

   logic [3:0]  state_ff;
   logic [31:0] cycle_start_ff;
   logic [31:0] fade_start_ff;
   logic [15:0] el_ff;
   logic [15:0] d_ff;
   logic        rfull_ff;
   logic [15:0] h_ff;
   logic [16:0] fade_ff;
   logic [16:0] breath_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] sq_v_ff;
   logic [32:0] sq_bit_ff;
   logic [33:0] sq_res_ff;
   logic [16:0] tt_ff;
   logic        neg_ff;
   logic [16:0] t2_ff;
   logic [15:0] inner_ff;
   logic [16:0] poly_ff;
   logic [17:0] sv_ff;

   logic [31:0] elapsed;
   logic        restart;
   logic [31:0] fs;
   logic [31:0] dlt;
   logic        rfull;

   logic        div_start;
   logic [15:0] div_rem_init;
   logic [15:0] div_dvd;
   logic [15:0] div_den;
   logic        div_done;
   logic [15:0] div_quot;
   logic [15:0] div_rem;

   logic [33:0] sq_trial;
   logic        sq_ge;
   logic [32:0] sq_v_in;
   logic [33:0] sq_res_in;

   logic [33:0] sin_sq;
   logic [29:0] sin_a;
   logic [32:0] sin_b;
   logic [33:0] sin_c;
   logic [17:0] smag;
   logic [33:0] sin_d;
   logic [16:0] t2_in;
   logic [15:0] inner_in;
   logic [16:0] poly_in;
   logic [17:0] sv_in;
   logic [16:0] breath_in;

   assign elapsed = req_now_ms - cycle_start_ff;
   assign restart = elapsed >= 32'(cfg.hue_period);
   assign fs      = (fade_start_ff == '0) ? req_now_ms : fade_start_ff;
   assign dlt     = req_now_ms - fs;
   assign rfull   = !(dlt < 32'(cfg.fade_in));

   always_comb begin
      div_start    = 1'b0;
      div_rem_init = '0;
      div_dvd      = '0;
      div_den      = '0;
      case (state_ff)
         F_HUE: begin
            div_start    = cfg.hue_period != '0;
            div_rem_init = el_ff;
            div_den      = cfg.hue_period;
         end
         F_RAMP: begin
            div_start    = !rfull_ff;
            div_rem_init = d_ff;
            div_den      = cfg.fade_in;
         end
         F_BMOD: begin
            div_start = cfg.breath_en && (cfg.breath_period != '0);
            div_dvd   = el_ff;
            div_den   = cfg.breath_period;
         end
         F_MWAIT: begin
            div_start    = div_done;
            div_rem_init = div_rem;
            div_den      = cfg.breath_period;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   lsrg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .dvd      (div_dvd),
      .den      (div_den),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      sq_trial  = sq_res_ff + 34'(sq_bit_ff);
      sq_ge     = 34'(sq_v_ff) >= sq_trial;
      sq_v_in   = sq_ge ? 33'(34'(sq_v_ff) - sq_trial) : sq_v_ff;
      sq_res_in = sq_ge ? (sq_res_ff >> 1) + 34'(sq_bit_ff) : (sq_res_ff >> 1);
   end

   always_comb begin
      sin_sq    = 34'(tt_ff) * 34'(tt_ff);
      t2_in     = sin_sq[32:16];
      sin_a     = 30'(t2_ff) * 30'(SIN_K3);
      inner_in  = 16'(32'(SIN_K2) - 32'(sin_a[29:16]));
      sin_b     = 33'(t2_ff) * 33'(inner_ff);
      poly_in   = 17'(32'(SIN_K1) - 32'(sin_b[32:16]));
      sin_c     = 34'(tt_ff) * 34'(poly_ff);
      smag      = (sin_c[33:16] > 18'(ONE_Q16)) ? 18'(ONE_Q16) : sin_c[33:16];
      sv_in     = neg_ff ? 18'(ONE_Q16) - smag : 18'(ONE_Q16) + smag;
      sin_d     = 34'(BR_GAIN) * 34'(sv_ff);
      breath_in = 17'(BR_BASE) + sin_d[33:17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         cycle_start_ff <= '0;
         fade_start_ff  <= '0;
         cnt_ff         <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  if (restart) begin
                     cycle_start_ff <= req_now_ms;
                  end
                  if (fade_start_ff == '0) begin
                     fade_start_ff <= req_now_ms;
                  end
                  el_ff    <= restart ? '0 : elapsed[15:0];
                  d_ff     <= dlt[15:0];
                  rfull_ff <= rfull;
                  state_ff <= F_HUE;
               end
            end
            F_HUE: begin
               if (cfg.hue_period == '0) begin
                  h_ff     <= '0;
                  state_ff <= F_RAMP;
               end else begin
                  state_ff <= F_HWAIT;
               end
            end
            F_HWAIT: begin
               if (div_done) begin
                  h_ff     <= div_quot;
                  state_ff <= F_RAMP;
               end
            end
            F_RAMP: begin
               if (rfull_ff) begin
                  sq_v_ff   <= {1'b1, 32'd0};
                  sq_res_ff <= '0;
                  sq_bit_ff <= {1'b1, 32'd0};
                  cnt_ff    <= '0;
                  state_ff  <= F_SQRT;
               end else begin
                  state_ff <= F_RWAIT;
               end
            end
            F_RWAIT: begin
               if (div_done) begin
                  sq_v_ff   <= {1'b0, div_quot, 16'd0};
                  sq_res_ff <= '0;
                  sq_bit_ff <= {1'b1, 32'd0};
                  cnt_ff    <= '0;
                  state_ff  <= F_SQRT;
               end
            end
            F_SQRT: begin
               sq_v_ff   <= sq_v_in;
               sq_res_ff <= sq_res_in;
               sq_bit_ff <= sq_bit_ff >> 2;
               cnt_ff    <= cnt_ff + 5'd1;
               if (cnt_ff == SQRT_LAST) begin
                  fade_ff  <= sq_res_in[16:0];
                  state_ff <= F_BMOD;
               end
            end
            F_BMOD: begin
               if (!cfg.breath_en) begin
                  breath_ff <= ONE_Q16;
                  state_ff  <= F_PUSH;
               end else if (cfg.breath_period == '0) begin
                  tt_ff    <= '0;
                  neg_ff   <= 1'b0;
                  state_ff <= F_SIN1;
               end else begin
                  state_ff <= F_MWAIT;
               end
            end
            F_MWAIT: begin
               if (div_done) begin
                  state_ff <= F_PWAIT;
               end
            end
            F_PWAIT: begin
               if (div_done) begin
                  tt_ff    <= sine_arg(div_quot);
                  neg_ff   <= div_quot[15];
                  state_ff <= F_SIN1;
               end
            end
            F_SIN1: begin
               t2_ff    <= t2_in;
               state_ff <= F_SIN2;
            end
            F_SIN2: begin
               inner_ff <= inner_in;
               state_ff <= F_SIN3;
            end
            F_SIN3: begin
               poly_ff  <= poly_in;
               state_ff <= F_SIN4;
            end
            F_SIN4: begin
               sv_ff    <= sv_in;
               state_ff <= F_SIN5;
            end
            F_SIN5: begin
               breath_ff <= breath_in;
               state_ff  <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = state_ff == F_IDLE;
   assign push             = (state_ff == F_PUSH) && !q_full;
   assign push_data.hue    = h_ff;
   assign push_data.fade   = fade_ff;
   assign push_data.breath = breath_ff;

endmodule

`default_nettype wire

// ----- sv/lsrg_fifo.sv -----
// two-entry queue of per-tick parameters between front and back end
// depends on lsrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsrg_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsrg_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output lsrg_pkg::entry_type pop_data,
   output logic                empty
);

   import lsrg_pkg::*;

   entry_type  slot_ff [2];
   logic [1:0] count_ff;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/lsrg_back.sv -----
// back end: per-led hue offset, hsv to rgb, fade and breath scaling
// depends on lsrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsrg_back #(
   parameter int LED_COUNT = lsrg_pkg::LED_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  lsrg_pkg::entry_type q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [5:0]          rsp_led_index,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_last_led
);

   import lsrg_pkg::*;

   localparam int          RW    = $clog2(LED_COUNT) + 1;
   localparam logic [16:0] OFF_Q = 17'(65536 / LED_COUNT);
   localparam logic [RW-1:0] OFF_R = RW'(65536 % LED_COUNT);
   localparam logic [RW-1:0] N_RW  = RW'(LED_COUNT);
   localparam logic [5:0]  LAST_IDX = 6'(LED_COUNT - 1);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_COL  = 2'd1;
   localparam logic [1:0] B_MUL  = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;

   logic [1:0]    state_ff;
   logic [15:0]   h_ff;
   logic [16:0]   fade_ff;
   logic [16:0]   breath_ff;
   logic [5:0]    idx_ff;
   logic [15:0]   oq_ff;
   logic [RW-1:0] or_ff;
   logic [16:0]   c_ff  [3];
   logic [41:0]   m1_ff [3];
   logic          valid_ff;
   logic [5:0]    idx_out_ff;
   logic [7:0]    chan_ff [3];
   logic          last_ff;

   logic [15:0]   hue;
   logic [18:0]   hp;
   logic [2:0]    sector;
   logic [16:0]   x;
   logic [16:0]   c_in [3];
   logic [24:0]   c255 [3];
   logic [41:0]   m1_in [3];
   logic [42:0]   m2 [3];
   logic [RW:0]   r_sum;
   logic          r_wrap;
   logic          out_free;
   logic          last;

   always_comb begin
      hue    = h_ff + oq_ff;
      hp     = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
      sector = hp[18:16];
      x      = sector[0] ? ONE_Q16 - {1'b0, hp[15:0]} : {1'b0, hp[15:0]};
      case (sector)
         3'd0: begin
            c_in[0] = ONE_Q16; c_in[1] = x;       c_in[2] = '0;
         end
         3'd1: begin
            c_in[0] = x;       c_in[1] = ONE_Q16; c_in[2] = '0;
         end
         3'd2: begin
            c_in[0] = '0;      c_in[1] = ONE_Q16; c_in[2] = x;
         end
         3'd3: begin
            c_in[0] = '0;      c_in[1] = x;       c_in[2] = ONE_Q16;
         end
         3'd4: begin
            c_in[0] = x;       c_in[1] = '0;      c_in[2] = ONE_Q16;
         end
         default: begin
            c_in[0] = ONE_Q16; c_in[1] = '0;      c_in[2] = x;
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         c255[k]  = {c_ff[k], 8'd0} - {8'd0, c_ff[k]};
         m1_in[k] = 42'(c255[k]) * 42'(fade_ff);
         m2[k]    = 43'(m1_ff[k][41:16]) * 43'(breath_ff);
      end
   end

   assign r_sum    = {1'b0, or_ff} + {1'b0, OFF_R};
   assign r_wrap   = r_sum >= {1'b0, N_RW};
   assign out_free = !valid_ff || rsp_ready;
   assign last     = idx_ff == LAST_IDX;
   assign pop      = (state_ff == B_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !((state_ff == B_OUT) && out_free)) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  h_ff      <= q_data.hue;
                  fade_ff   <= q_data.fade;
                  breath_ff <= q_data.breath;
                  idx_ff    <= '0;
                  oq_ff     <= '0;
                  or_ff     <= '0;
                  state_ff  <= B_COL;
               end
            end
            B_COL: begin
               c_ff     <= c_in;
               state_ff <= B_MUL;
            end
            B_MUL: begin
               m1_ff    <= m1_in;
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (out_free) begin
                  valid_ff   <= 1'b1;
                  idx_out_ff <= idx_ff;
                  last_ff    <= last;
                  for (int k = 0; k < 3; k++) begin
                     chan_ff[k] <= m2[k][39:32];
                  end
                  idx_ff <= idx_ff + 6'd1;
                  if (r_wrap) begin
                     or_ff <= RW'(r_sum - {1'b0, N_RW});
                     oq_ff <= 16'(oq_ff + OFF_Q[15:0] + 16'd1);
                  end else begin
                     or_ff <= r_sum[RW-1:0];
                     oq_ff <= oq_ff + OFF_Q[15:0];
                  end
                  state_ff <= last ? B_IDLE : B_COL;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_led_index = idx_out_ff;
   assign rsp_red       = chan_ff[0];
   assign rsp_green     = chan_ff[1];
   assign rsp_blue      = chan_ff[2];
   assign rsp_last_led  = last_ff;

endmodule

`default_nettype wire

// ----- sv/led_strip_rainbow_generator.sv -----
// led strip rainbow generator: one tick in, one color transaction per led out
// depends on lsrg_pkg, lsrg_front, lsrg_fifo, lsrg_back
//
// req channel: one transaction per millisecond tick, carrying req_now_ms.
// rsp channel: LED_COUNT transactions per tick in led order, led_index,
// red, green, blue, with last_led set on the final led.
// csr port: csr_we writes csr_index (hue period, fade-in time, breathing
// enable, breath period) with csr_wdata in the same cycle; write only idle.
// front end time per tick is set by the shared divider and 17-step root,
// longer with breathing. back end steps each led through B_COL, B_MUL and
// B_OUT and waits in B_OUT while the output register is held; a two-entry
// queue lets the front start the next tick while the back still emits.
// reset clears the hue cycle start and the fade-in start and loads the
// default registers. a stalled receiver holds the output register; the
// back end then waits, and a full queue holds the front with req_ready low.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_rainbow_generator #(
   parameter int LED_COUNT = lsrg_pkg::LED_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_led,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import lsrg_pkg::*;

   cfg_type   cfg_ff;
   logic      push;
   entry_type push_data;
   logic      q_full;
   logic      pop;
   entry_type pop_data;
   logic      q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_period    <= HUE_PERIOD_RST;
         cfg_ff.fade_in       <= FADE_IN_RST;
         cfg_ff.breath_en     <= BREATH_EN_RST;
         cfg_ff.breath_period <= BREATH_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_HUE_PERIOD:    cfg_ff.hue_period    <= csr_wdata;
            REG_FADE_IN:       cfg_ff.fade_in       <= csr_wdata;
            REG_BREATH_EN:     cfg_ff.breath_en     <= csr_wdata[0];
            REG_BREATH_PERIOD: cfg_ff.breath_period <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lsrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_now_ms (req_now_ms),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   lsrg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   lsrg_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_led_index (rsp_led_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last_led  (rsp_last_led)
   );

endmodule

`default_nettype wire

// ----- sv/lsrg_checker.sv -----
// port-level checks of the rainbow generator, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lsrg_checker #(
   parameter int LED_COUNT = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_led_index,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic        rsp_last_led
);

   localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

   `LSRG_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   `LSRG_ASSERT_CLK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_led_index) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "rsp payload changed")

   `LSRG_ASSERT_CLK(a_last_idx, rsp_valid && rsp_last_led |-> rsp_led_index == LAST_IDX, "last led index wrong")

   `LSRG_ASSERT_CLK(a_idx_last, rsp_valid && rsp_led_index == LAST_IDX |-> rsp_last_led, "last led flag missing")

   `LSRG_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind led_strip_rainbow_generator lsrg_checker #(.LED_COUNT(LED_COUNT)) u_checker (.*);

`default_nettype wire

// ----- test/tb_led_strip_rainbow_generator.sv -----
// led strip rainbow generator testbench: directed and random ticks, scoreboard
// predicts per-led colors; depends on lsrg_pkg and led_strip_rainbow_generator
`timescale 1ns / 1ps

module tb_led_strip_rainbow_generator;
   import lsrg_pkg::*;

   localparam int LEDS = LED_COUNT_DEF;

   typedef struct {
      logic [5:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_led;
   } color_type;

   class color_scoreboard;
      color_type   pending[$];
      logic [15:0] hue_period, fade_in, breath_period;
      logic        breath_en;
      logic [31:0] cycle_start, fade_start;
      int          errors;

      function new();
         hue_period = HUE_PERIOD_RST;
         fade_in = FADE_IN_RST;
         breath_en = BREATH_EN_RST;
         breath_period = BREATH_PERIOD_RST;
         cycle_start = 0;
         fade_start = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            REG_HUE_PERIOD: hue_period = val;
            REG_FADE_IN: fade_in = val;
            REG_BREATH_EN: breath_en = val[0];
            REG_BREATH_PERIOD: breath_period = val;
            default: ;
         endcase
      endfunction

      function longint root(longint v);
         longint res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function longint sine(logic [15:0] p);
         logic [1:0] q;
         longint t, tt, t2, inner, poly, s;
         q = p[15:14];
         t = q[0] ? (16384 - p[13:0]) : p[13:0];
         tt = t << 2;
         t2 = (tt * tt) >> 16;
         inner = 42177 - ((t2 * 4770) >> 16);
         poly = 102944 - ((t2 * inner) >> 16);
         s = (tt * poly) >> 16;
         if (s > 65536) s = 65536;
         return q[1] ? -s : s;
      endfunction

      function void note_tick(logic [31:0] now);
         logic [31:0] elapsed, d;
         longint h, ramp, fade, br, off, hi, hp, f, x, p;
         longint c[3];
         logic [63:0] v;
         int sector;
         color_type e;
         elapsed = now - cycle_start;
         if (elapsed >= hue_period) begin
            cycle_start = now;
            elapsed = 0;
         end
         h = (hue_period != 0) ? ((longint'(elapsed) << 16) / hue_period) : 0;
         if (fade_start == 0) fade_start = now;
         d = now - fade_start;
         ramp = (d < fade_in) ? ((longint'(d) << 16) / fade_in) : 65536;
         fade = root(ramp << 16);
         br = 65536;
         if (breath_en) begin
            p = 0;
            if (breath_period != 0)
               p = (longint'(elapsed % breath_period) << 16) / breath_period;
            br = 6554 + ((58982 * (65536 + sine(p[15:0]))) >> 17);
         end
         for (int i = 0; i < LEDS; i++) begin
            off = (longint'(i) << 16) / LEDS;
            hi = (h + off) & 16'hffff;
            hp = hi * 6;
            sector = hp >> 16;
            f = hp & 16'hffff;
            x = sector[0] ? 65536 - f : f;
            case (sector)
               0: c = '{65536, x, 0};
               1: c = '{x, 65536, 0};
               2: c = '{0, 65536, x};
               3: c = '{0, x, 65536};
               4: c = '{x, 0, 65536};
               default: c = '{65536, 0, x};
            endcase
            e.led_index = 6'(i);
            v = (((c[0] * 255 * fade) >> 16) * br) >> 32;
            e.red = v[7:0];
            v = (((c[1] * 255 * fade) >> 16) * br) >> 32;
            e.green = v[7:0];
            v = (((c[2] * 255 * fade) >> 16) * br) >> 32;
            e.blue = v[7:0];
            e.last_led = (i == LEDS - 1);
            pending.push_back(e);
         end
      endfunction

      function void check_color(color_type got);
         color_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected transaction led %0d", $time, got.led_index);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.led_index !== e.led_index || got.red !== e.red || got.green !== e.green
             || got.blue !== e.blue || got.last_led !== e.last_led) begin
            $display("%0t mismatch expected %0d %h %h %h %b actual %0d %h %h %h %b", $time,
                     e.led_index, e.red, e.green, e.blue, e.last_led, got.led_index,
                     got.red, got.green, got.blue, got.last_led);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, rsp_ready = 0, csr_we = 0;
   logic        req_ready, rsp_valid, rsp_last_led;
   logic [31:0] req_now_ms = 0;
   logic [5:0]  rsp_led_index;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic [1:0]  csr_index = REG_HUE_PERIOD;
   logic [15:0] csr_wdata = 0;
   logic        calm = 0, hold_off = 0;
   logic [31:0] clock_ms = 1;
   int          rx_gap = 0;
   color_scoreboard colors;

   led_strip_rainbow_generator u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // receiver side, random idle bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         colors.check_color('{rsp_led_index, rsp_red, rsp_green, rsp_blue, rsp_last_led});
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (rx_gap != 0) begin
         rsp_ready <= 1'b0;
         rx_gap <= rx_gap - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rx_gap <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      colors.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_tick(logic [31:0] now);
      csr_we <= 0;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      colors.note_tick(now);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (colors.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_ticks(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + $urandom_range(1000, 70000);
            default: clock_ms = clock_ms + $urandom_range(1, 400);
         endcase
         send_tick(clock_ms);
      end
   endtask

   initial begin
      colors = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero tick leaves fade unlatched, then extremes
      send_tick(0);
      send_tick(32'd1);
      send_tick(32'd2500);
      send_tick(32'd4999);
      send_tick(32'd5001);
      send_tick(32'hffffffff);
      send_tick(32'h00000005);
      drain();
      write_reg(REG_HUE_PERIOD, 16'd0);
      write_reg(REG_FADE_IN, 16'd0);
      write_reg(REG_BREATH_EN, 16'd1);
      write_reg(REG_BREATH_PERIOD, 16'd0);
      send_tick(32'd100);
      send_tick(32'd200);
      drain();
      write_reg(REG_HUE_PERIOD, 16'hffff);
      write_reg(REG_FADE_IN, 16'hffff);
      write_reg(REG_BREATH_PERIOD, 16'hffff);
      for (int i = 0; i < 6; i++) send_tick(32'h5555aaaa + i * 16384);
      drain();
      write_reg(REG_HUE_PERIOD, 16'd1);
      write_reg(REG_FADE_IN, 16'd1);
      write_reg(REG_BREATH_PERIOD, 16'd1);
      send_tick(32'd7);
      send_tick(32'd8);
      drain();
      // random phases, each with its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_HUE_PERIOD, 16'($urandom_range(1, 65535)));
         write_reg(REG_FADE_IN, 16'($urandom_range(0, 65535)));
         write_reg(REG_BREATH_EN, 16'($urandom_range(0, 1)));
         write_reg(REG_BREATH_PERIOD, 16'($urandom_range(0, 65535)));
         if (ph == 2) begin
            hold_off = 1;
            fork
               begin
                  repeat (600) @(posedge clock);
                  hold_off = 0;
               end
               random_ticks(30);
            join
         end else begin
            random_ticks(30);
         end
         drain();
      end
      calm = 1;
      random_ticks(20);
      drain();
      if (colors.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
